// ----- src/ldrf_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldrf_pkg
// Shared types and constants of the local dynamic range filter: register
// indexes, arithmetic widths, controller states and the command and status
// groups between controller and datapath.
// ---------------------------------------------------------------------------
package ldrf_pkg;

    // Default frame size limits.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // Neighborhood geometry.
    localparam int WIN_RAD  = 2;
    localparam int WIN_SIDE = 2 * WIN_RAD + 1;
    localparam int WIN_CW   = 3;

    // Pixel and configuration widths.
    localparam int CH_W       = 8;
    localparam int PIX_W      = 4 * CH_W;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ALPHA_W    = 9;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Reset values of the frame size registers.
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    // Arithmetic: sum of 25 r+g+b values, gain times sum, full product.
    localparam int SUM_W   = 15;
    localparam int M1_W    = 24;
    localparam int PROD_W  = 32;
    localparam int Q_W     = 9;
    localparam int VAL_W   = 11;

    // Division by 4876875 as a multiply by ceil(2^54 / 4876875) and a shift
    // by 54; exact for every dividend below 2^31.
    localparam logic [PROD_W-1:0] LDR_RECIP = 32'd3693840525;
    localparam int                RECIP_SH  = 54;

    // Controller states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CTR  = 8'b0000_0010,
        S_WIN  = 8'b0000_0100,
        S_SUM  = 8'b0000_1000,
        S_MUL1 = 8'b0001_0000,
        S_MUL2 = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic cap_ctr;
        logic win_rd;
        logic mul1;
        logic mul2;
        logic div_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic interior;
        logic win_last;
        logic out_free;
    } status_t;

endpackage

// ----- src/ldrf_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldrf_in_if
// Input channel: a pixel or flush transaction with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ldrf_in_if;
    import ldrf_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_alpha;

    modport source (output valid, kind, in_blue, in_green, in_red, in_alpha, input ready);
    modport sink   (input valid, kind, in_blue, in_green, in_red, in_alpha, output ready);
endinterface

// ----- src/ldrf_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldrf_out_if
// Output channel: a filtered pixel transaction with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ldrf_out_if;
    import ldrf_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_alpha;
    logic            frame_last;

    modport source (output valid, out_blue, out_green, out_red, out_alpha, frame_last,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, out_alpha, frame_last,
                    output ready);
endinterface

// ----- src/ldrf_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldrf_dp
// Datapath: configuration registers, frame counters, pixel history memory,
// window walk and sum, gain multiply, constant divide and output register.
// ---------------------------------------------------------------------------
module ldrf_dp #(
    parameter int MAX_WIDTH  = ldrf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ldrf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ldrf_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ldrf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_kind,
    input  logic [ldrf_pkg::CH_W-1:0]       in_blue,
    input  logic [ldrf_pkg::CH_W-1:0]       in_green,
    input  logic [ldrf_pkg::CH_W-1:0]       in_red,
    input  logic [ldrf_pkg::CH_W-1:0]       in_alpha,
    input  ldrf_pkg::cmd_t                  cmd,
    output ldrf_pkg::status_t               st,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [ldrf_pkg::CH_W-1:0]       out_blue,
    output logic [ldrf_pkg::CH_W-1:0]       out_green,
    output logic [ldrf_pkg::CH_W-1:0]       out_red,
    output logic [ldrf_pkg::CH_W-1:0]       out_alpha,
    output logic                            frame_last
);
    import ldrf_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int ROWW  = $clog2(MAX_HEIGHT);
    localparam int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DEPTH = 2 * WIN_RAD * MAX_WIDTH + 2 * WIN_RAD + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LAGW  = $clog2(2 * MAX_WIDTH + 3);

    // Add with wrap into the circular history.
    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW-1:0] r;
        if (v >= (AW+1)'(DEPTH))
            r = AW'(v - (AW+1)'(DEPTH));
        else
            r = v[AW-1:0];
        return r;
    endfunction

    // Configuration registers.
    logic [ALPHA_W-1:0]    alpha_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  cfg_restart;

    assign cfg_restart = cfg_we && (cfg_idx == CFG_WIDTH || cfg_idx == CFG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= '0;
            width_reg  <= CFG_DATA_W'(RST_WIDTH);
            height_reg <= CFG_DATA_W'(RST_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ALPHA:  alpha_reg  <= cfg_data[ALPHA_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Effective frame size, clipped to the supported range.
    logic [WW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic [LAGW-1:0] lag;
    logic [CNTW-1:0] frame_total;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        if (height_reg == '0)
            eff_h = HW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);
    end

    assign lag = LAGW'({eff_w, 1'b0}) + LAGW'(2);

    // Pixel count of the frame follows the size registers without delay.
    assign frame_total = CNTW'(eff_w) * CNTW'(eff_h);

    // Frame position counters.
    logic [CNTW-1:0] recv_reg;
    logic [CNTW-1:0] outc_reg;
    logic [CNTW-1:0] outc_inc;
    logic [AW-1:0]   wr_addr_reg;
    logic [AW-1:0]   out_addr_reg;
    logic [COLW-1:0] out_col_reg;
    logic [ROWW-1:0] out_row_reg;
    logic            pix;
    logic            emit;
    logic            last;
    logic            interior;
    logic [AW-1:0]   base_addr;

    assign pix      = !in_kind && (recv_reg < frame_total);
    assign outc_inc = outc_reg + CNTW'(1);
    assign last     = (outc_inc == frame_total);
    assign emit     = pix ? ({1'b0, recv_reg} >= ({1'b0, outc_reg} + (CNTW+1)'(lag)))
                          : (recv_reg >= frame_total && outc_reg < frame_total);
    assign interior = (int'(out_row_reg) >= WIN_RAD)
                   && (int'(out_row_reg) + WIN_RAD < int'(eff_h))
                   && (int'(out_col_reg) >= WIN_RAD)
                   && (int'(out_col_reg) + WIN_RAD < int'(eff_w));
    assign base_addr = wrap({1'b0, out_addr_reg} + (AW+1)'(DEPTH) - (AW+1)'(lag));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_reg     <= '0;
            outc_reg     <= '0;
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else if (cfg_restart)
        begin
            recv_reg     <= '0;
            outc_reg     <= '0;
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else if (cmd.take)
        begin
            if (pix)
            begin
                recv_reg    <= recv_reg + CNTW'(1);
                wr_addr_reg <= wrap({1'b0, wr_addr_reg} + (AW+1)'(1));
            end
            if (emit)
            begin
                outc_reg     <= outc_inc;
                out_addr_reg <= wrap({1'b0, out_addr_reg} + (AW+1)'(1));
                if (WW'(out_col_reg) + WW'(1) == eff_w)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROWW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COLW'(1);
                end
                // The final result of the frame starts the next one.
                if (last)
                begin
                    recv_reg     <= '0;
                    outc_reg     <= '0;
                    wr_addr_reg  <= '0;
                    out_addr_reg <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                end
            end
        end
    end

    // Pixel history memory with one write and one registered read port.
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic [AW-1:0]    win_addr_reg;
    logic [AW-1:0]    rd_addr;

    assign rd_addr = cmd.win_rd ? win_addr_reg : out_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take && pix)
            mem[wr_addr_reg] <= {in_alpha, in_red, in_green, in_blue};
        rd_data_reg <= mem[rd_addr];
    end

    // Per-result control: border flag, last flag and window walk position.
    logic              interior_reg;
    logic              last_reg;
    logic              acc_valid_reg;
    logic [AW-1:0]     win_row_reg;
    logic [AW-1:0]     row_next;
    logic [WIN_CW-1:0] di_reg;
    logic [WIN_CW-1:0] dj_reg;

    assign row_next = wrap({1'b0, win_row_reg} + (AW+1)'(eff_w));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interior_reg  <= 1'b0;
            last_reg      <= 1'b0;
            acc_valid_reg <= 1'b0;
            di_reg        <= '0;
            dj_reg        <= '0;
        end
        else
        begin
            acc_valid_reg <= cmd.win_rd;
            if (cmd.take && emit)
            begin
                interior_reg <= interior;
                last_reg     <= last;
                di_reg       <= '0;
                dj_reg       <= '0;
            end
            else if (cmd.win_rd)
            begin
                if (dj_reg == WIN_CW'(WIN_SIDE - 1))
                begin
                    dj_reg <= '0;
                    di_reg <= di_reg + WIN_CW'(1);
                end
                else
                begin
                    dj_reg <= dj_reg + WIN_CW'(1);
                end
            end
        end
    end

    // Window addresses step along a row, then jump one image row down.
    always_ff @(posedge clk)
    begin
        if (cmd.take && emit)
        begin
            win_row_reg  <= base_addr;
            win_addr_reg <= base_addr;
        end
        else if (cmd.win_rd)
        begin
            if (dj_reg == WIN_CW'(WIN_SIDE - 1))
            begin
                win_row_reg  <= row_next;
                win_addr_reg <= row_next;
            end
            else
            begin
                win_addr_reg <= wrap({1'b0, win_addr_reg} + (AW+1)'(1));
            end
        end
    end

    // Center pixel capture and brightness sum over the window.
    logic [PIX_W-1:0] ctr_reg;
    logic [SUM_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_ctr)
            ctr_reg <= rd_data_reg;
        if (cmd.take)
            sum_reg <= '0;
        else if (acc_valid_reg)
            sum_reg <= sum_reg + SUM_W'(rd_data_reg[7:0]) + SUM_W'(rd_data_reg[15:8])
                     + SUM_W'(rd_data_reg[23:16]);
    end

    // Gain times sum, then times each channel, then the constant divide as
    // a multiply by the reciprocal and a shift, for all channels at once.
    logic [ALPHA_W-1:0]  abs_gain;
    logic [M1_W-1:0]     m1_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_reg [3];
    logic [Q_W-1:0]      q_reg [3];
    logic [2*PROD_W-1:0] qprod [3];

    assign abs_gain = alpha_reg[ALPHA_W-1] ? (~alpha_reg + ALPHA_W'(1)) : alpha_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            qprod[ch] = (2*PROD_W)'(prod_reg[ch]) * (2*PROD_W)'(LDR_RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            m1_reg  <= M1_W'(abs_gain) * M1_W'(sum_reg);
            neg_reg <= alpha_reg[ALPHA_W-1];
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (cmd.mul2)
                prod_reg[ch] <= PROD_W'(m1_reg) * PROD_W'(ctr_reg[CH_W*ch +: CH_W]);
            if (cmd.div_step)
                q_reg[ch] <= qprod[ch][RECIP_SH +: Q_W];
        end
    end

    // Apply the signed correction and saturate to 0..255.
    logic [CH_W-1:0]  fin [3];
    logic [VAL_W-1:0] val [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (neg_reg)
                val[ch] = VAL_W'(ctr_reg[CH_W*ch +: CH_W]) - VAL_W'(q_reg[ch]);
            else
                val[ch] = VAL_W'(ctr_reg[CH_W*ch +: CH_W]) + VAL_W'(q_reg[ch]);
            if (val[ch][VAL_W-1])
                fin[ch] = '0;
            else if (val[ch] > VAL_W'(255))
                fin[ch] = '1;
            else
                fin[ch] = val[ch][CH_W-1:0];
        end
    end

    // Output register; a waiting result does not block new input.
    logic            out_valid_reg;
    logic [CH_W-1:0] ob_reg;
    logic [CH_W-1:0] og_reg;
    logic [CH_W-1:0] or_reg;
    logic [CH_W-1:0] oa_reg;
    logic            ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            ob_reg <= interior_reg ? fin[0] : ctr_reg[7:0];
            og_reg <= interior_reg ? fin[1] : ctr_reg[15:8];
            or_reg <= interior_reg ? fin[2] : ctr_reg[23:16];
            oa_reg <= ctr_reg[31:24];
            ol_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_blue   = ob_reg;
    assign out_green  = og_reg;
    assign out_red    = or_reg;
    assign out_alpha  = oa_reg;
    assign frame_last = ol_reg;

    // Status toward the controller.
    assign st.emit     = emit;
    assign st.interior = interior_reg;
    assign st.win_last = (di_reg == WIN_CW'(WIN_SIDE - 1)) && (dj_reg == WIN_CW'(WIN_SIDE - 1));
    assign st.out_free = !out_valid_reg || out_ready;

    // Checks on counters and sequencing.
    a_outc_range: assert property (@(posedge clk) disable iff (!rst_n)
        outc_reg < frame_total) else $error("result count beyond frame size");
    a_recv_range: assert property (@(posedge clk) disable iff (!rst_n)
        recv_reg <= frame_total) else $error("received count beyond frame size");
    a_win_interior: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_rd |-> interior_reg) else $error("window read for a border pixel");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready)) else $error("output overwritten");
endmodule

// ----- src/ldrf_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldrf_ctrl
// Controller: sequences acceptance, center read, window reads, multiply,
// divide and output load for one transaction at a time.
// ---------------------------------------------------------------------------
module ldrf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ldrf_pkg::status_t st,
    output ldrf_pkg::cmd_t    cmd
);
    import ldrf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (st.emit)
                        state_next = S_CTR;
                end
            end
            S_CTR:
            begin
                cmd.cap_ctr = 1'b1;
                state_next  = st.interior ? S_WIN : S_OUT;
            end
            S_WIN:
            begin
                cmd.win_rd = 1'b1;
                if (st.win_last)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencing checks.
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && !st.emit) |=> state_reg == S_IDLE)
        else $error("left idle without a result");
    a_win_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WIN && st.win_last) |=> state_reg == S_SUM)
        else $error("window walk did not end");
    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> state_reg == S_OUT)
        else $error("divide did not end");
endmodule

// ----- src/local_dynamic_range_filter_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// local_dynamic_range_filter_core
// 5x5 local dynamic range filter on a raster BGRA stream.
// ---------------------------------------------------------------------------
// Sequence: a transaction that gives no result leaves the controller idle;
// a border result passes the center read and the output load; an interior
// result also takes 25 window reads through the single history read port,
// a sum, two multiplies and a reciprocal divide. The output load waits
// while the output register is still full; the result then waits there
// while new input is taken.
// Reset: asynchronous, active low; alpha 0, size 640x480, counters cleared.
module local_dynamic_range_filter_core #(
    parameter int MAX_WIDTH  = ldrf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ldrf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ldrf_in_if.sink                         pix_in,
    ldrf_out_if.source                      pix_out,
    input  logic                            cfg_we,
    input  logic [ldrf_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ldrf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ldrf_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic    in_ready;

    assign pix_in.ready = in_ready;

    ldrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ldrf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_kind    (pix_in.kind),
        .in_blue    (pix_in.in_blue),
        .in_green   (pix_in.in_green),
        .in_red     (pix_in.in_red),
        .in_alpha   (pix_in.in_alpha),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (pix_out.ready),
        .out_valid  (pix_out.valid),
        .out_blue   (pix_out.out_blue),
        .out_green  (pix_out.out_green),
        .out_red    (pix_out.out_red),
        .out_alpha  (pix_out.out_alpha),
        .frame_last (pix_out.frame_last)
    );
endmodule
